// ===== src/bmrd_pkg.sv =====
// Package for the binary mask rectangular dilation block.
// Holds sizes, operation and register codes, and the controller/datapath link types.
// No dependencies.
`default_nettype none

package bmrd_pkg;

    // Mask geometry.
    localparam int MAX_COLS = 64;
    localparam int MAX_ROWS = 64;
    localparam int COL_AW   = $clog2(MAX_COLS);
    localparam int ROW_AW   = $clog2(MAX_ROWS);

    // Field and register widths.
    localparam int FUNC_W  = 2;
    localparam int IDX_W   = 6;
    localparam int GRID_W  = 7;
    localparam int REACH_W = 6;
    localparam int CFG_AW  = 3;
    localparam int CFG_DW  = 7;

    // Operation codes.
    localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_PRESENT = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ    = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_AW-1:0] CFG_GRID_COLS   = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_GRID_ROWS   = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_REACH_LEFT  = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_REACH_RIGHT = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_REACH_DOWN  = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_REACH_UP    = 3'd5;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture the accepted item
        logic prep;      // compute rectangle bounds and column span
        logic clear;     // forget every stored row
        logic rd_item;   // read the row named by the item
        logic rd_row;    // read the row under the row counter
        logic wr_row;    // write the widened row back and step the counter
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              hit;       // set source bin inside the grid
        logic              row_last;  // row counter sits on the top row of the rectangle
    } t_status;

endpackage

`default_nettype wire

// ===== src/bmrd_ctrl.sv =====
// Controller state machine for the binary mask rectangular dilation block.
// Sequences item capture, row read-modify-write passes and result hand-off.
// Depends on bmrd_pkg.
`default_nettype none

module bmrd_ctrl (
    input  wire                logic i_clk,
    input  wire                logic i_rst_n,
    input  wire                logic i_in_valid,
    input  wire                logic i_out_free,
    input  bmrd_pkg::t_status  i_status,
    output logic               o_in_ready,
    output logic               o_out_load,
    output bmrd_pkg::t_cmd     o_cmd
);
    import bmrd_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PREP = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_WR   = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        o_out_load = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = S_OUT;
                priority if (i_status.func == FUNC_CLEAR) begin
                    o_cmd.clear = 1'b1;
                end else if (i_status.func == FUNC_PRESENT) begin
                    if (i_status.hit) begin
                        n_state = S_RD;
                    end
                end else if (i_status.func == FUNC_READ) begin
                    o_cmd.rd_item = 1'b1;
                end else begin
                    // The unused operation code does nothing but report.
                end
            end
            S_RD: begin
                o_cmd.rd_row = 1'b1;
                n_state      = S_WR;
            end
            S_WR: begin
                o_cmd.wr_row = 1'b1;
                n_state      = i_status.row_last ? S_OUT : S_RD;
            end
            S_OUT: begin
                if (i_out_free) begin
                    o_out_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ===== src/bmrd_dp.sv =====
// Datapath of the binary mask rectangular dilation block: configuration registers,
// item registers, rectangle bounds, the row memory with its row valid bits.
// Depends on bmrd_pkg.
`default_nettype none

module bmrd_dp (
    input  wire                      logic i_clk,
    input  wire                      logic i_rst_n,
    input  wire                      logic i_cfg_we,
    input  wire [bmrd_pkg::CFG_AW-1:0] i_cfg_idx,
    input  wire [bmrd_pkg::CFG_DW-1:0] i_cfg_data,
    input  wire [bmrd_pkg::FUNC_W-1:0] i_func,
    input  wire [bmrd_pkg::IDX_W-1:0]  i_col,
    input  wire [bmrd_pkg::IDX_W-1:0]  i_row,
    input  wire                      logic i_src_bit,
    input  bmrd_pkg::t_cmd           i_cmd,
    output bmrd_pkg::t_status        o_status,
    output logic                     o_out_bit,
    output logic                     o_out_of_grid
);
    import bmrd_pkg::*;

    // Configuration.
    logic [GRID_W-1:0]  r_grid_cols;
    logic [GRID_W-1:0]  r_grid_rows;
    logic [REACH_W-1:0] r_reach_left;
    logic [REACH_W-1:0] r_reach_right;
    logic [REACH_W-1:0] r_reach_down;
    logic [REACH_W-1:0] r_reach_up;

    // Item being worked on.
    logic [FUNC_W-1:0] r_func;
    logic [IDX_W-1:0]  r_col;
    logic [IDX_W-1:0]  r_row;
    logic              r_bit;

    // Rectangle.
    logic [MAX_COLS-1:0] r_span;
    logic [ROW_AW-1:0]   r_ycnt;
    logic [ROW_AW-1:0]   r_yhi;

    // Row store and its valid bits.
    logic [MAX_COLS-1:0] r_mem [MAX_ROWS];
    logic [MAX_ROWS-1:0] r_row_valid;
    logic [MAX_COLS-1:0] r_q;
    logic                r_q_valid;

    logic [GRID_W-1:0]   used_cols;
    logic [GRID_W-1:0]   used_rows;
    logic                outside;
    logic [IDX_W-1:0]    xlo;
    logic [IDX_W-1:0]    ylo;
    logic [GRID_W-1:0]   xhi_raw;
    logic [GRID_W-1:0]   yhi_raw;
    logic [GRID_W-1:0]   xhi_clamp;
    logic [GRID_W-1:0]   yhi_clamp;
    logic [COL_AW-1:0]   xhi;
    logic [COL_AW-1:0]   top_gap;
    logic [MAX_COLS-1:0] n_span;
    logic [ROW_AW-1:0]   rd_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_cols   <= GRID_W'(MAX_COLS);
            r_grid_rows   <= GRID_W'(MAX_ROWS);
            r_reach_left  <= '0;
            r_reach_right <= '0;
            r_reach_down  <= '0;
            r_reach_up    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_GRID_COLS:   r_grid_cols   <= i_cfg_data[GRID_W-1:0];
                CFG_GRID_ROWS:   r_grid_rows   <= i_cfg_data[GRID_W-1:0];
                CFG_REACH_LEFT:  r_reach_left  <= i_cfg_data[REACH_W-1:0];
                CFG_REACH_RIGHT: r_reach_right <= i_cfg_data[REACH_W-1:0];
                CFG_REACH_DOWN:  r_reach_down  <= i_cfg_data[REACH_W-1:0];
                CFG_REACH_UP:    r_reach_up    <= i_cfg_data[REACH_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Grid sizes saturate at the mask dimensions.
    assign used_cols = (r_grid_cols > GRID_W'(MAX_COLS)) ? GRID_W'(MAX_COLS) : r_grid_cols;
    assign used_rows = (r_grid_rows > GRID_W'(MAX_ROWS)) ? GRID_W'(MAX_ROWS) : r_grid_rows;
    assign outside   = ({1'b0, r_col} >= used_cols) || ({1'b0, r_row} >= used_rows);

    // Rectangle bounds, clamped at zero below and at the grid edge above.
    assign xlo     = (r_col > r_reach_left) ? (r_col - r_reach_left) : '0;
    assign ylo     = (r_row > r_reach_down) ? (r_row - r_reach_down) : '0;
    assign xhi_raw = {1'b0, r_col} + {1'b0, r_reach_right};
    assign yhi_raw = {1'b0, r_row} + {1'b0, r_reach_up};
    assign xhi_clamp = (xhi_raw > used_cols - 1'b1) ? (used_cols - 1'b1) : xhi_raw;
    assign yhi_clamp = (yhi_raw > used_rows - 1'b1) ? (used_rows - 1'b1) : yhi_raw;
    assign xhi     = xhi_clamp[COL_AW-1:0];
    assign top_gap = COL_AW'(MAX_COLS - 1) - xhi;
    assign n_span  = ({MAX_COLS{1'b1}} << xlo[COL_AW-1:0])
                   & ({MAX_COLS{1'b1}} >> top_gap);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_func;
            r_col  <= i_col;
            r_row  <= i_row;
            r_bit  <= i_src_bit;
        end
        if (i_cmd.prep) begin
            r_span <= n_span;
            r_ycnt <= ylo[ROW_AW-1:0];
            r_yhi  <= yhi_clamp[ROW_AW-1:0];
        end else if (i_cmd.wr_row) begin
            r_ycnt <= r_ycnt + 1'b1;
        end
    end

    // Row store: one read port with registered data, one write port.
    assign rd_addr = i_cmd.rd_row ? r_ycnt : r_row[ROW_AW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_row) begin
            r_mem[r_ycnt] <= (r_q_valid ? r_q : '0) | r_span;
        end
        if (i_cmd.rd_row || i_cmd.rd_item) begin
            r_q <= r_mem[rd_addr];
        end
    end

    // A row that is not valid reads as all zeros.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
            r_q_valid   <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_row_valid <= '0;
            end else if (i_cmd.wr_row) begin
                r_row_valid[r_ycnt] <= 1'b1;
            end
            if (i_cmd.rd_row || i_cmd.rd_item) begin
                r_q_valid <= r_row_valid[rd_addr];
            end
        end
    end

    assign o_status.func     = r_func;
    assign o_status.hit      = r_bit && !outside;
    assign o_status.row_last = (r_ycnt == r_yhi);

    assign o_out_bit     = (r_func == FUNC_READ) && !outside && r_q_valid
                         && r_q[r_col[COL_AW-1:0]];
    assign o_out_of_grid = outside;

endmodule

`default_nettype wire

// ===== src/binary_mask_rect_dilation.sv =====
// Top level of the binary mask rectangular dilation block.
// Instantiates bmrd_ctrl and bmrd_dp and holds the result register; uses bmrd_pkg.
//
// The block keeps a 64 x 64 bit output mask, one memory word per row. Each input
// item carries one operation: clear the mask, present one source bin, or read one
// output bin; every item gives exactly one result item with the read bit and an
// out-of-grid flag. A presented bin that is set and inside the configured grid ORs
// ones over the rectangle reaching reach_left/reach_right bins along x and
// reach_down/reach_up bins along y, clamped to the grid. Steps per item: a clear,
// a read, an ignored present or an unused operation code goes through the
// accepting state, one state that works out the rectangle and one in which the
// result enters the output register; a set present also does one read and one
// write for each touched row in between, through the single port pair of the row
// memory. Clear acts on all rows at once because every row has a valid bit that
// resets with the block; a row never written since reads as zeros. No pass over
// the memory is needed after reset. The next item is accepted in the cycle after
// the result is placed in the output register, which holds it until the downstream
// side takes it; while that register is still full the block waits and the item
// time grows by the stall. Configuration registers are written through the plain
// write port and must only change while no item is in flight.
`default_nettype none

module binary_mask_rect_dilation (
    input  wire  logic        i_clk,
    input  wire  logic        i_rst_n,
    // Configuration write port.
    input  wire  logic        i_cfg_we,
    input  wire  logic [2:0]  i_cfg_idx,
    input  wire  logic [6:0]  i_cfg_data,
    // Input items.
    input  wire  logic        s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire  logic [15:0] s_axis_tdata,   // func[1:0], col[7:2], row[13:8], src_bit[14]
    // Result items.
    output logic              m_axis_tvalid,
    input  wire  logic        m_axis_tready,
    output logic [7:0]        m_axis_tdata    // out_bit[0], out_of_grid[1]
);
    import bmrd_pkg::*;

    t_cmd    cmd;
    t_status status;
    logic    out_free;
    logic    out_load;
    logic    res_bit;
    logic    res_oog;

    logic    r_m_valid;
    logic    r_m_bit;
    logic    r_m_oog;

    // The result register is free when empty or being drained this cycle.
    assign out_free = !r_m_valid || m_axis_tready;

    bmrd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_out_free (out_free),
        .i_status   (status),
        .o_in_ready (s_axis_tready),
        .o_out_load (out_load),
        .o_cmd      (cmd)
    );

    bmrd_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_func        (s_axis_tdata[1:0]),
        .i_col         (s_axis_tdata[7:2]),
        .i_row         (s_axis_tdata[13:8]),
        .i_src_bit     (s_axis_tdata[14]),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_out_bit     (res_bit),
        .o_out_of_grid (res_oog)
    );

    // Result register: loaded when the controller finishes an item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (out_load) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_m_bit <= res_bit;
            r_m_oog <= res_oog;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {6'b0, r_m_oog, r_m_bit};

endmodule

`default_nettype wire

// ===== bench/binary_mask_rect_dilation_tb.sv =====
// Self-checking testbench for binary_mask_rect_dilation: a directed table, then random phases.
// Each result is checked against a typed-in value or an in-bench model of the dilated mask; depends on bmrd_pkg.
`default_nettype none

module binary_mask_rect_dilation_tb;

    import bmrd_pkg::*;

    // The operation code that the block leaves unused, sent to check that it does nothing.
    localparam logic [FUNC_W-1:0] FUNC_NOP = 2'd3;

    // A set present touching all 64 rows, with a read and a write per row, is the longest
    // the block is ever busy. The tail wait covers it once more; the watchdog allows
    // that, the longest receiver stall and the longest sender gap several times over.
    localparam int TAIL_CYCLES     = 150;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int RANDOM_PHASES   = 16;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int TABLE_ROWS      = 41;

    // One expected result item, tagged with the order in which its input was accepted.
    typedef struct {
        logic        out_bit;
        logic        out_of_grid;
        int unsigned seq;
    } t_mask_result;

    // One row of the directed table: either a register write or an item. An item's
    // result is typed in when it is obvious, otherwise it comes from the mask model.
    typedef struct packed {
        logic              is_reg;
        logic [CFG_AW-1:0] reg_idx;
        logic [CFG_DW-1:0] reg_val;
        logic [FUNC_W-1:0] func;
        logic [IDX_W-1:0]  col;
        logic [IDX_W-1:0]  row;
        logic              src_bit;
        logic              known;
        logic              want_bit;
        logic              want_oog;
    } t_stim_row;

    logic              i_clk;
    logic              i_rst_n       = 1'b0;
    logic              i_cfg_we      = 1'b0;
    logic [2:0]        i_cfg_idx     = '0;
    logic [6:0]        i_cfg_data    = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [15:0]       s_axis_tdata  = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [7:0]        m_axis_tdata;

    // Model of the block: the dilated mask, one word per row, and its register copies.
    logic [MAX_COLS-1:0] dilated_mask [0:MAX_ROWS-1];
    logic [GRID_W-1:0]   grid_cols_q  = 7'd64;
    logic [GRID_W-1:0]   grid_rows_q  = 7'd64;
    logic [REACH_W-1:0]  reach_left_q  = '0;
    logic [REACH_W-1:0]  reach_right_q = '0;
    logic [REACH_W-1:0]  reach_down_q  = '0;
    logic [REACH_W-1:0]  reach_up_q    = '0;

    t_mask_result expected_results [$];
    t_mask_result front_result;
    t_stim_row    stim_table [0:TABLE_ROWS-1];
    int unsigned  accepted_items = 0;
    int unsigned  mismatches     = 0;
    int unsigned  quiet_cycles   = 0;
    int unsigned  rx_stall       = 0;
    int unsigned  rx_roll;
    bit           tx_eager       = 1'b0;
    bit           rx_eager       = 1'b0;

    binary_mask_rect_dilation uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // func[1:0], col[7:2], row[13:8], src_bit[14]
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)    // out_bit[0], out_of_grid[1]
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // A grid register above the mask size saturates at the mask size.
    function automatic int used_size(input logic [GRID_W-1:0] grid);
        return (grid > 7'd64) ? 64 : int'(grid);
    endfunction

    // Advances the mask model by one item and returns the result it should produce.
    task automatic dilate_predict(input logic [FUNC_W-1:0] func, input logic [IDX_W-1:0] col,
                                  input logic [IDX_W-1:0] row, input logic src_bit,
                                  output logic rd_bit, output logic outside);
        int nc, nr, ci, ri, xlo, xhi, ylo, yhi;
        nc = used_size(grid_cols_q);
        nr = used_size(grid_rows_q);
        ci = col;
        ri = row;
        outside = (ci >= nc) || (ri >= nr);
        rd_bit = 1'b0;
        case (func)
            FUNC_CLEAR: begin
                // Clear wipes every row, whatever the grid size.
                for (int y = 0; y < MAX_ROWS; y++) dilated_mask[y] = '0;
            end
            FUNC_PRESENT: begin
                if (src_bit && !outside) begin
                    xlo = (ci > int'(reach_left_q)) ? ci - int'(reach_left_q) : 0;
                    ylo = (ri > int'(reach_down_q)) ? ri - int'(reach_down_q) : 0;
                    xhi = ci + int'(reach_right_q);
                    yhi = ri + int'(reach_up_q);
                    if (xhi > nc - 1) xhi = nc - 1;
                    if (yhi > nr - 1) yhi = nr - 1;
                    for (int y = ylo; y <= yhi; y++)
                        for (int x = xlo; x <= xhi; x++) dilated_mask[y][x] = 1'b1;
                end
            end
            FUNC_READ: begin
                if (!outside) rd_bit = dilated_mask[ri][ci];
            end
            default: begin
            end
        endcase
    endtask

    function automatic t_stim_row item_row(input logic [FUNC_W-1:0] func,
                                           input logic [IDX_W-1:0] col,
                                           input logic [IDX_W-1:0] row, input logic src_bit);
        t_stim_row r;
        r = '0;
        r.func    = func;
        r.col     = col;
        r.row     = row;
        r.src_bit = src_bit;
        return r;
    endfunction

    function automatic t_stim_row known_row(input logic [FUNC_W-1:0] func,
                                            input logic [IDX_W-1:0] col,
                                            input logic [IDX_W-1:0] row, input logic src_bit,
                                            input logic want_bit, input logic want_oog);
        t_stim_row r;
        r = item_row(func, col, row, src_bit);
        r.known    = 1'b1;
        r.want_bit = want_bit;
        r.want_oog = want_oog;
        return r;
    endfunction

    function automatic t_stim_row reg_row(input logic [CFG_AW-1:0] idx,
                                          input logic [CFG_DW-1:0] val);
        t_stim_row r;
        r = '0;
        r.is_reg  = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        mismatches++;
    endtask

    // Sender gaps: none in eager stretches, otherwise mostly short with the odd long one.
    function automatic int pick_gap();
        int unsigned roll;
        if (tx_eager) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Mostly an index inside the used grid; now and then anything the field can hold.
    function automatic logic [IDX_W-1:0] pick_index(input int used);
        if (used > 0 && $urandom_range(0, 9) != 0) return IDX_W'($urandom_range(0, used - 1));
        return IDX_W'($urandom_range(0, 63));
    endfunction

    function automatic logic [CFG_DW-1:0] pick_grid();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 5)  return 7'd0;
        if (roll < 15) return 7'd1;
        if (roll < 25) return 7'd64;
        if (roll < 35) return CFG_DW'($urandom_range(65, 127));
        return CFG_DW'($urandom_range(2, 64));
    endfunction

    function automatic logic [CFG_DW-1:0] pick_reach();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 15) return 7'd0;
        if (roll < 25) return 7'd63;
        if (roll < 35) return CFG_DW'($urandom_range(0, 63));
        return CFG_DW'($urandom_range(0, 4));
    endfunction

    // Register writes happen only while the block is idle. The write enable is left high
    // on return so that back-to-back writes never lower and raise it in one step; the next
    // item lowers it.
    task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            CFG_GRID_COLS:   grid_cols_q   = val;
            CFG_GRID_ROWS:   grid_rows_q   = val;
            CFG_REACH_LEFT:  reach_left_q  = val[REACH_W-1:0];
            CFG_REACH_RIGHT: reach_right_q = val[REACH_W-1:0];
            CFG_REACH_DOWN:  reach_down_q  = val[REACH_W-1:0];
            CFG_REACH_UP:    reach_up_q    = val[REACH_W-1:0];
            default: begin
            end
        endcase
    endtask

    // Holds the sender back until every outstanding result has been taken.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    // Offers one item and waits for it to be taken. tvalid stays high on return so that
    // a following item with no gap keeps the bus busy without a dead cycle.
    task automatic send_item(input logic [FUNC_W-1:0] func, input logic [IDX_W-1:0] col,
                             input logic [IDX_W-1:0] row, input logic src_bit,
                             input logic known, input logic want_bit, input logic want_oog);
        int           gap;
        logic         rd_bit;
        logic         outside;
        t_mask_result res;
        gap = pick_gap();
        i_cfg_we <= 1'b0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, src_bit, row, col, func};
        do @(posedge i_clk); while (!s_axis_tready);
        dilate_predict(func, col, row, src_bit, rd_bit, outside);
        res.out_bit     = known ? want_bit : rd_bit;
        res.out_of_grid = known ? want_oog : outside;
        res.seq         = accepted_items;
        accepted_items++;
        expected_results = {expected_results, res};
    endtask

    // The receiver: ready for good in eager stretches, otherwise stalls of random length.
    always @(posedge i_clk) begin
        if (rx_stall > 0) begin
            rx_stall      <= rx_stall - 1;
            m_axis_tready <= 1'b0;
        end else if (rx_eager) begin
            m_axis_tready <= 1'b1;
        end else begin
            rx_roll = $urandom_range(0, 99);
            if (rx_roll < 70) begin
                m_axis_tready <= 1'b1;
            end else if (rx_roll < 95) begin
                m_axis_tready <= 1'b0;
                rx_stall      <= $urandom_range(0, 2);
            end else begin
                m_axis_tready <= 1'b0;
                rx_stall      <= $urandom_range(10, 60);
            end
        end
    end

    // Each result taken is compared with the oldest outstanding expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("result 0x%02h with no item outstanding",
                                          m_axis_tdata));
            end else begin
                front_result = expected_results.pop_front();
                if (m_axis_tdata[0] !== front_result.out_bit)
                    report_mismatch($sformatf("item %0d out_bit got %b want %b",
                                              front_result.seq, m_axis_tdata[0],
                                              front_result.out_bit));
                if (m_axis_tdata[1] !== front_result.out_of_grid)
                    report_mismatch($sformatf("item %0d out_of_grid got %b want %b",
                                              front_result.seq, m_axis_tdata[1],
                                              front_result.out_of_grid));
            end
        end
    end

    // The watchdog ends the run when neither side has moved an item for too long.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == WATCHDOG_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial begin
        logic [FUNC_W-1:0] func;
        logic [IDX_W-1:0]  col;
        logic [IDX_W-1:0]  row;
        int unsigned       roll;

        for (int y = 0; y < MAX_ROWS; y++) dilated_mask[y] = '0;

        // Directed part. It opens on the reset settings: empty mask, full grid, no reach.
        stim_table = '{
            known_row(FUNC_READ,     6'd0,  6'd0,  1'b0, 1'b0, 1'b0),
            known_row(FUNC_READ,     6'd63, 6'd63, 1'b0, 1'b0, 1'b0),
            item_row (FUNC_PRESENT,  6'd63, 6'd63, 1'b1),
            known_row(FUNC_READ,     6'd63, 6'd63, 1'b0, 1'b1, 1'b0),
            item_row (FUNC_READ,     6'd62, 6'd63, 1'b0),
            item_row (FUNC_PRESENT,  6'd0,  6'd0,  1'b0),
            known_row(FUNC_READ,     6'd0,  6'd0,  1'b0, 1'b0, 1'b0),
            // The unused code reads nothing, even where the mask is set.
            known_row(FUNC_NOP,      6'd63, 6'd63, 1'b1, 1'b0, 1'b0),
            known_row(FUNC_CLEAR,    6'd0,  6'd0,  1'b0, 1'b0, 1'b0),
            known_row(FUNC_READ,     6'd63, 6'd63, 1'b0, 1'b0, 1'b0),
            // Widest reach in every direction: a single set bin fills the whole grid.
            reg_row(CFG_REACH_LEFT,  7'd63),
            reg_row(CFG_REACH_RIGHT, 7'd63),
            reg_row(CFG_REACH_DOWN,  7'd63),
            reg_row(CFG_REACH_UP,    7'd63),
            item_row (FUNC_PRESENT,  6'd31, 6'd17, 1'b1),
            known_row(FUNC_READ,     6'd0,  6'd0,  1'b0, 1'b1, 1'b0),
            // Columns saturate at the mask width; zero rows leaves no bin in the grid,
            // so everything is out of grid, the clear included.
            reg_row(CFG_GRID_COLS,   7'd127),
            reg_row(CFG_GRID_ROWS,   7'd0),
            known_row(FUNC_READ,     6'd5,  6'd5,  1'b0, 1'b0, 1'b1),
            known_row(FUNC_PRESENT,  6'd5,  6'd5,  1'b1, 1'b0, 1'b1),
            known_row(FUNC_CLEAR,    6'd0,  6'd0,  1'b0, 1'b0, 1'b1),
            // The smallest grid: one bin, with bins beside it out of grid and ignored.
            reg_row(CFG_GRID_COLS,   7'd1),
            reg_row(CFG_GRID_ROWS,   7'd1),
            known_row(FUNC_READ,     6'd0,  6'd0,  1'b0, 1'b0, 1'b0),
            known_row(FUNC_READ,     6'd1,  6'd0,  1'b0, 1'b0, 1'b1),
            known_row(FUNC_PRESENT,  6'd0,  6'd1,  1'b1, 1'b0, 1'b1),
            known_row(FUNC_PRESENT,  6'd0,  6'd0,  1'b1, 1'b0, 1'b0),
            known_row(FUNC_READ,     6'd0,  6'd0,  1'b0, 1'b1, 1'b0),
            // An uneven rectangle clamped against the top and right edges of the grid.
            reg_row(CFG_GRID_COLS,   7'd10),
            reg_row(CFG_GRID_ROWS,   7'd20),
            reg_row(CFG_REACH_LEFT,  7'd2),
            reg_row(CFG_REACH_RIGHT, 7'd3),
            reg_row(CFG_REACH_DOWN,  7'd1),
            reg_row(CFG_REACH_UP,    7'd4),
            item_row (FUNC_PRESENT,  6'd8,  6'd18, 1'b1),
            item_row (FUNC_READ,     6'd9,  6'd19, 1'b0),
            item_row (FUNC_READ,     6'd5,  6'd17, 1'b0),
            item_row (FUNC_READ,     6'd6,  6'd17, 1'b0),
            known_row(FUNC_NOP,      6'd63, 6'd63, 1'b0, 1'b0, 1'b1),
            // Rows saturate too; a bin on the top row is clamped at the top.
            reg_row(CFG_GRID_ROWS,   7'd127),
            item_row (FUNC_PRESENT,  6'd0,  6'd63, 1'b1)
        };

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < TABLE_ROWS; i++) begin
            if (stim_table[i].is_reg) begin
                drain_results();
                write_reg(stim_table[i].reg_idx, stim_table[i].reg_val);
            end else begin
                send_item(stim_table[i].func, stim_table[i].col, stim_table[i].row,
                          stim_table[i].src_bit, stim_table[i].known,
                          stim_table[i].want_bit, stim_table[i].want_oog);
            end
        end

        // Random part: each phase waits for the block to go idle, picks fresh settings for
        // all six registers, then streams items checked against the mask model.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            drain_results();
            write_reg(CFG_GRID_COLS,   pick_grid());
            write_reg(CFG_GRID_ROWS,   pick_grid());
            write_reg(CFG_REACH_LEFT,  pick_reach());
            write_reg(CFG_REACH_RIGHT, pick_reach());
            write_reg(CFG_REACH_DOWN,  pick_reach());
            write_reg(CFG_REACH_UP,    pick_reach());
            tx_eager = ($urandom_range(0, 3) == 0);
            rx_eager = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                roll = $urandom_range(0, 99);
                if (roll < 3)       func = FUNC_CLEAR;
                else if (roll < 48) func = FUNC_PRESENT;
                else if (roll < 95) func = FUNC_READ;
                else                func = FUNC_NOP;
                col = pick_index(used_size(grid_cols_q));
                row = pick_index(used_size(grid_rows_q));
                send_item(func, col, row, ($urandom_range(0, 3) != 0), 1'b0, 1'b0, 1'b0);
                // Now and then the sender holds off until the block has caught up.
                if ($urandom_range(0, 49) == 0) drain_results();
            end
        end

        drain_results();
        tx_eager = 1'b0;
        rx_eager = 1'b0;
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
src/bmrd_pkg.sv
src/bmrd_ctrl.sv
src/bmrd_dp.sv
src/binary_mask_rect_dilation.sv
bench/binary_mask_rect_dilation_tb.sv
